// ===== hdl/pmm_pkg.sv =====
`timescale 1ns / 1ps

package pmm_pkg;

    // Magnitude width that every vector is brought to before the length is taken
    localparam int NORM_BITS = 30;
    // Width of the integer square root of a sum of three NORM_BITS squares
    localparam int SQRT_BITS = 31;
    // Width of that sum
    localparam int SUM_BITS  = 2 * NORM_BITS + 2;

    // Column codes on the result port
    typedef enum logic [1:0] {
        COL_RIGHT = 2'd0,
        COL_UP    = 2'd1,
        COL_FRONT = 2'd2,
        COL_POS   = 2'd3
    } t_col;

endpackage

// ===== hdl/pose_to_model_matrix_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tdata: pos xyz, up xyz, front xyz, scale xyz
// m_axis    out  tvalid/tready/tlast       tdata: column, entry x, y, z; tuser: degenerate
//
// Each pose gives four column transactions; the four beats on the single result port bound
// the sustained pose rate. A pose may enter in any cycle the port is free.
// Most of the pipeline depth to the first column lies in the bit-serial square root and
// division stages of the normalizers (up and front side by side, then right).
// Reset clears valid bits and the output register's full flag and column; payload registers are not reset.
// A stall on the result port holds the whole pipeline; bubbles still move up.

module pose_to_model_matrix_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // pos_x, pos_y, pos_z, up_x, up_y, up_z, front_x, front_y, front_z,
    // scale_x, scale_y, scale_z, then zero fill
    input  logic [((12*WORD_BITS+7)/8)*8-1:0]       i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // column_index, entry_x, entry_y, entry_z, then zero fill
    output logic [((3*WORD_BITS+2+7)/8)*8-1:0]      o_m_axis_tdata,
    output logic                                    o_m_axis_tlast,
    // degenerate
    output logic                                    o_m_axis_tuser
);
    import pmm_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int TDO = ((3*W+2+7)/8)*8;
    localparam int SBA = 3*W;
    localparam int SBB = 3 + 3*W;
    localparam int SBX = SBA + SBB + 2*(3 + 3*(F+1)) + 1;

    logic               w_en;
    logic [11:0][W-1:0] w_f;
    logic [2:0]         w_up_neg, w_fr_neg, w_s_neg;
    logic [2:0][W-1:0]  w_up_mag, w_fr_mag, w_s_mag;

    logic               a_valid, a_zero, b_valid, b_zero;
    logic [2:0]         a_neg, b_neg;
    logic [2:0][F:0]    a_mag, b_mag;
    logic [SBA-1:0]     a_sb;
    logic [SBB-1:0]     b_sb;

    logic               x_valid;
    logic [2:0]         x_neg;
    logic [2:0][2*F+1:0] x_mag;
    logic [SBX-1:0]     x_sb;

    logic               c_valid, c_zero;
    logic [2:0]         c_neg;
    logic [2:0][F:0]    c_mag;
    logic [SBX-1:0]     c_sb;
    logic [2:0][W-1:0]  c_pos;
    logic [2:0]         c_s_neg;
    logic [2:0][W-1:0]  c_s_mag;
    logic [2:0]         c_up_neg, c_fr_neg;
    logic [2:0][F:0]    c_up_mag, c_fr_mag;
    logic               c_degen;

    logic               s_valid, s_degen;
    logic [8:0][W-1:0]  s_ent;
    logic [SBA-1:0]     s_sb;

    logic               r_full;
    t_col               r_col;
    t_col               n_col;
    logic [8:0][W-1:0]  r_ent;
    logic [2:0][W-1:0]  r_pos;
    logic               r_deg;
    logic               w_out_acc;
    logic               w_last;
    logic [W-1:0]       w_ox, w_oy, w_oz;

    // Unpack fields and split into sign and magnitude
    always_comb begin
        for (int k = 0; k < 12; k++) begin
            w_f[k] = i_s_axis_tdata[k*W +: W];
        end
        for (int j = 0; j < 3; j++) begin
            w_up_neg[j] = w_f[3+j][W-1];
            w_fr_neg[j] = w_f[6+j][W-1];
            w_s_neg[j]  = w_f[9+j][W-1];
            w_up_mag[j] = w_up_neg[j] ? (~w_f[3+j] + 1'b1) : w_f[3+j];
            w_fr_mag[j] = w_fr_neg[j] ? (~w_f[6+j] + 1'b1) : w_f[6+j];
            w_s_mag[j]  = w_s_neg[j]  ? (~w_f[9+j] + 1'b1) : w_f[9+j];
        end
    end

    // Advance when the output register frees up, or to fill a bubble
    assign w_out_acc = r_full & i_m_axis_tready;
    assign w_last    = (r_col == COL_POS);
    assign w_en      = !r_full || (w_out_acc && w_last) || !s_valid;
    assign o_s_axis_tready = w_en;

    pmm_norm #(.IW(W), .FRAC_BITS(F), .SBW(SBA)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_neg   (w_up_neg),
        .i_mag   (w_up_mag),
        .i_sb    ({w_f[2], w_f[1], w_f[0]}),
        .o_valid (a_valid),
        .o_zero  (a_zero),
        .o_neg   (a_neg),
        .o_mag   (a_mag),
        .o_sb    (a_sb)
    );

    pmm_norm #(.IW(W), .FRAC_BITS(F), .SBW(SBB)) u_norm_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_neg   (w_fr_neg),
        .i_mag   (w_fr_mag),
        .i_sb    ({w_s_neg, w_s_mag}),
        .o_valid (b_valid),
        .o_zero  (b_zero),
        .o_neg   (b_neg),
        .o_mag   (b_mag),
        .o_sb    (b_sb)
    );

    pmm_cross #(.FRAC_BITS(F), .SBW(SBX)) u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (a_valid & b_valid),
        .i_up_neg (a_neg),
        .i_up_mag (a_mag),
        .i_fr_neg (b_neg),
        .i_fr_mag (b_mag),
        .i_sb     ({a_sb, b_sb, a_neg, a_mag, b_neg, b_mag, a_zero | b_zero}),
        .o_valid  (x_valid),
        .o_neg    (x_neg),
        .o_mag    (x_mag),
        .o_sb     (x_sb)
    );

    pmm_norm #(.IW(2*F+2), .FRAC_BITS(F), .SBW(SBX)) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (x_valid),
        .i_neg   (x_neg),
        .i_mag   (x_mag),
        .i_sb    (x_sb),
        .o_valid (c_valid),
        .o_zero  (c_zero),
        .o_neg   (c_neg),
        .o_mag   (c_mag),
        .o_sb    (c_sb)
    );

    assign {c_pos, c_s_neg, c_s_mag, c_up_neg, c_up_mag, c_fr_neg, c_fr_mag, c_degen} = c_sb;

    pmm_scale #(.WORD_BITS(W), .FRAC_BITS(F), .SBW(SBA)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (c_valid),
        .i_u_neg ({c_fr_neg, c_up_neg, c_neg}),
        .i_u_mag ({c_fr_mag, c_up_mag, c_mag}),
        .i_s_neg (c_s_neg),
        .i_s_mag (c_s_mag),
        .i_degen (c_degen | c_zero),
        .i_sb    (c_pos),
        .o_valid (s_valid),
        .o_ent   (s_ent),
        .o_degen (s_degen),
        .o_sb    (s_sb)
    );

    // Step through the four columns
    always_comb begin
        unique case (r_col)
            COL_RIGHT: n_col = COL_UP;
            COL_UP:    n_col = COL_FRONT;
            COL_FRONT: n_col = COL_POS;
            COL_POS:   n_col = COL_RIGHT;
            default:   n_col = COL_RIGHT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_col  <= COL_RIGHT;
        end else if (w_en && s_valid) begin
            r_full <= 1'b1;
            r_col  <= COL_RIGHT;
        end else if (w_out_acc && w_last) begin
            r_full <= 1'b0;
        end else if (w_out_acc) begin
            r_col  <= n_col;
        end
    end

    // Load the matrix into the output register
    always_ff @(posedge i_clk) begin
        if (w_en && s_valid) begin
            r_ent <= s_ent;
            r_pos <= s_sb;
            r_deg <= s_degen;
        end
    end

    // Select the column on the port
    always_comb begin
        case (r_col)
            COL_RIGHT: begin w_ox = r_ent[0]; w_oy = r_ent[1]; w_oz = r_ent[2]; end
            COL_UP:    begin w_ox = r_ent[3]; w_oy = r_ent[4]; w_oz = r_ent[5]; end
            COL_FRONT: begin w_ox = r_ent[6]; w_oy = r_ent[7]; w_oz = r_ent[8]; end
            default:   begin w_ox = r_pos[0]; w_oy = r_pos[1]; w_oz = r_pos[2]; end
        endcase
    end

    assign o_m_axis_tvalid = r_full;
    assign o_m_axis_tdata  = TDO'({w_oz, w_oy, w_ox, r_col});
    assign o_m_axis_tlast  = w_last;
    assign o_m_axis_tuser  = r_deg;

endmodule

// ===== hdl/pmm_norm.sv =====
`timescale 1ns / 1ps

module pmm_norm #(
    parameter int IW        = 32,
    parameter int FRAC_BITS = 16,
    parameter int SBW       = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2:0]                  i_neg,
    input  logic [2:0][IW-1:0]          i_mag,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_valid,
    output logic                        o_zero,
    output logic [2:0]                  o_neg,
    output logic [2:0][FRAC_BITS:0]     o_mag,
    output logic [SBW-1:0]              o_sb
);
    import pmm_pkg::*;

    localparam int LV  = $clog2(IW);
    localparam int SQN = SQRT_BITS;
    localparam int DN  = FRAC_BITS + 1;
    localparam int RW  = SUM_BITS;
    localparam int DW  = SQN + FRAC_BITS + 1;
    localparam int LAT = LV + 3 + SQN + DN;
    localparam int DLW = 3 + 1 + SBW;

    // Leading-zero shift stages
    logic [2:0][IW-1:0]        r_lz [0:LV];
    logic [IW-1:0]             r_or [0:LV];
    // Square and sum stages
    logic [2:0][NORM_BITS-1:0] w_c;
    logic [2:0][NORM_BITS-1:0] r_c1;
    logic [2:0][2*NORM_BITS-1:0] r_sq;
    // Square root stages, index 0 is the sum register
    logic [RW-1:0]             r_srem [0:SQN];
    logic [SQN-1:0]            r_sq_q [0:SQN];
    logic [2:0][NORM_BITS-1:0] r_sc   [0:SQN];
    // Division stages
    logic [2:0][DW-1:0]        r_drem [1:DN];
    logic [2:0][FRAC_BITS:0]   r_dq   [1:DN];
    logic [SQN-1:0]            r_dlen [1:DN];
    // Control delay line
    logic [DLW-1:0]            r_dl [0:LAT-1];
    logic                      r_vl [0:LAT-1];
    logic                      w_in_zero;
    logic [2:0]                w_neg_raw;

    assign w_in_zero = ~|(i_mag[0] | i_mag[1] | i_mag[2]);

    // Carry signs, zero flag and sideband alongside the datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl[0] <= {i_neg, w_in_zero, i_sb};
            for (int k = 1; k < LAT; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vl[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vl[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
        end
    end

    // Capture magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lz[0] <= i_mag;
            r_or[0] <= i_mag[0] | i_mag[1] | i_mag[2];
        end
    end

    // Shift all three left until the largest has its top bit set
    for (genvar k = 0; k < LV; k++) begin : g_lz
        localparam int SH = 1 << (LV - 1 - k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_or[k][IW-1 -: SH] == '0) begin
                    for (int j = 0; j < 3; j++) begin
                        r_lz[k+1][j] <= r_lz[k][j] << SH;
                    end
                    r_or[k+1] <= r_or[k] << SH;
                end else begin
                    r_lz[k+1] <= r_lz[k];
                    r_or[k+1] <= r_or[k];
                end
            end
        end
    end

    // Take the top NORM_BITS bits of the normalized word, or zero-fill a narrower word at the bottom
    for (genvar j = 0; j < 3; j++) begin : g_cut
        if (IW >= NORM_BITS) begin : g_right
            assign w_c[j] = r_lz[LV][j][IW-1 -: NORM_BITS];
        end else begin : g_left
            assign w_c[j] = {r_lz[LV][j], {(NORM_BITS - IW){1'b0}}};
        end
    end

    // Square components, then sum them
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= w_c;
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= w_c[j] * w_c[j];
            end
            r_sc[0]   <= r_c1;
            r_srem[0] <= RW'(r_sq[0]) + RW'(r_sq[1]) + RW'(r_sq[2]);
            r_sq_q[0] <= '0;
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 1; k <= SQN; k++) begin : g_sqrt
        localparam int B = SQN - k;
        logic [RW+1:0] w_t;
        logic          w_take;
        assign w_t    = (((RW+2)'(r_sq_q[k-1]) << 1) + ((RW+2)'(1) << B)) << B;
        assign w_take = {2'b00, r_srem[k-1]} >= w_t;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[k] <= w_take ? (r_srem[k-1] - w_t[RW-1:0]) : r_srem[k-1];
                r_sq_q[k] <= w_take ? (r_sq_q[k-1] | (SQN'(1) << B)) : r_sq_q[k-1];
                r_sc[k]   <= r_sc[k-1];
            end
        end
    end

    // Divide each component by the length, one quotient bit per stage
    for (genvar k = 1; k <= DN; k++) begin : g_div
        localparam int B = DN - k;
        logic [2:0][DW-1:0]      w_prem;
        logic [2:0][FRAC_BITS:0] w_pq;
        logic [SQN-1:0]          w_plen;
        logic [DW-1:0]           w_d;
        if (k == 1) begin : g_first
            for (genvar j = 0; j < 3; j++) begin : g_j
                assign w_prem[j] = DW'(r_sc[SQN][j]) << FRAC_BITS;
            end
            assign w_pq   = '0;
            assign w_plen = r_sq_q[SQN];
        end else begin : g_next
            assign w_prem = r_drem[k-1];
            assign w_pq   = r_dq[k-1];
            assign w_plen = r_dlen[k-1];
        end
        assign w_d = DW'(w_plen) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    if (w_prem[j] >= w_d) begin
                        r_drem[k][j] <= w_prem[j] - w_d;
                        r_dq[k][j]   <= w_pq[j] | ((FRAC_BITS+1)'(1) << B);
                    end else begin
                        r_drem[k][j] <= w_prem[j];
                        r_dq[k][j]   <= w_pq[j];
                    end
                end
                r_dlen[k] <= w_plen;
            end
        end
    end

    // Drive results; a zero vector gives zero components
    assign {w_neg_raw, o_zero, o_sb} = r_dl[LAT-1];
    assign o_valid = r_vl[LAT-1];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            o_mag[j] = o_zero ? '0 : r_dq[DN][j];
            o_neg[j] = w_neg_raw[j] & (o_mag[j] != '0);
        end
    end

endmodule

// ===== hdl/pmm_cross.sv =====
`timescale 1ns / 1ps

module pmm_cross #(
    parameter int FRAC_BITS = 16,
    parameter int SBW       = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [2:0]                    i_up_neg,
    input  logic [2:0][FRAC_BITS:0]       i_up_mag,
    input  logic [2:0]                    i_fr_neg,
    input  logic [2:0][FRAC_BITS:0]       i_fr_mag,
    input  logic [SBW-1:0]                i_sb,
    output logic                          o_valid,
    output logic [2:0]                    o_neg,
    output logic [2:0][2*FRAC_BITS+1:0]   o_mag,
    output logic [SBW-1:0]                o_sb
);
    localparam int SV = FRAC_BITS + 2;
    localparam int PV = 2 * SV;

    logic signed [SV-1:0] w_up [3];
    logic signed [SV-1:0] w_fr [3];
    logic signed [PV-1:0] r_p  [3];
    logic signed [PV-1:0] r_q  [3];
    logic [2:0]           r_neg;
    logic [2:0][2*FRAC_BITS+1:0] r_mag;
    logic [SBW-1:0]       r_sb1;
    logic [SBW-1:0]       r_sb2;
    logic                 r_v1;
    logic                 r_v2;

    // Rebuild signed unit components
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_up[j] = i_up_neg[j] ? -$signed({1'b0, i_up_mag[j]}) : $signed({1'b0, i_up_mag[j]});
            w_fr[j] = i_fr_neg[j] ? -$signed({1'b0, i_fr_mag[j]}) : $signed({1'b0, i_fr_mag[j]});
        end
    end

    // Form the six products, then the three differences
    for (genvar i = 0; i < 3; i++) begin : g_comp
        localparam int J = (i + 1) % 3;
        localparam int L = (i + 2) % 3;
        logic signed [PV:0] w_d;
        logic [PV:0]        w_abs;
        assign w_d   = r_p[i] - r_q[i];
        assign w_abs = w_d[PV] ? $unsigned(-w_d) : $unsigned(w_d);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[i]   <= w_up[J] * w_fr[L];
                r_q[i]   <= w_up[L] * w_fr[J];
                r_neg[i] <= w_d[PV];
                r_mag[i] <= w_abs[2*FRAC_BITS+1:0];
            end
        end
    end

    // Delay sideband with the data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb1 <= i_sb;
            r_sb2 <= r_sb1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;
    assign o_sb    = r_sb2;

endmodule

// ===== hdl/pmm_scale.sv =====
`timescale 1ns / 1ps

module pmm_scale #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int SBW       = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [8:0]                  i_u_neg,
    input  logic [8:0][FRAC_BITS:0]     i_u_mag,
    input  logic [2:0]                  i_s_neg,
    input  logic [2:0][WORD_BITS-1:0]   i_s_mag,
    input  logic                        i_degen,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_valid,
    output logic [8:0][WORD_BITS-1:0]   o_ent,
    output logic                        o_degen,
    output logic [SBW-1:0]              o_sb
);
    localparam int H  = (WORD_BITS + 1) / 2;
    localparam int HW = WORD_BITS - H;
    localparam int PW = FRAC_BITS + 1 + WORD_BITS;

    logic [FRAC_BITS+H:0]  r_lo [9];
    logic [FRAC_BITS+HW:0] r_hi [9];
    logic [8:0]            r_neg;
    logic [8:0][WORD_BITS-1:0] r_ent;
    logic                  r_deg1;
    logic                  r_deg2;
    logic [SBW-1:0]        r_sb1;
    logic [SBW-1:0]        r_sb2;
    logic                  r_v1;
    logic                  r_v2;

    // Partial products, then combine, shift, saturate, zero a degenerate pose and sign
    for (genvar e = 0; e < 9; e++) begin : g_ent
        localparam int C = e / 3;
        logic [PW-1:0] w_p;
        logic [PW-1:0] w_val;
        logic [PW-1:0] w_lim;
        logic [PW-1:0] w_sat;
        logic [WORD_BITS-1:0] w_w;
        assign w_p   = (PW'(r_hi[e]) << H) + PW'(r_lo[e]);
        assign w_val = w_p >> FRAC_BITS;
        assign w_lim = (PW'(1) << (WORD_BITS - 1)) - (r_neg[e] ? PW'(0) : PW'(1));
        assign w_sat = (w_val > w_lim) ? w_lim : w_val;
        assign w_w   = r_deg1 ? '0 : w_sat[WORD_BITS-1:0];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[e]  <= i_u_mag[e] * i_s_mag[C][H-1:0];
                r_hi[e]  <= i_u_mag[e] * i_s_mag[C][WORD_BITS-1:H];
                r_neg[e] <= i_u_neg[e] ^ i_s_neg[C];
                r_ent[e] <= r_neg[e] ? (~w_w + 1'b1) : w_w;
            end
        end
    end

    // Delay flag and sideband
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_deg1 <= i_degen;
            r_deg2 <= r_deg1;
            r_sb1  <= i_sb;
            r_sb2  <= r_sb1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_ent   = r_ent;
    assign o_degen = r_deg2;
    assign o_sb    = r_sb2;

endmodule

// ===== hdl/pmm_checker.sv =====
`timescale 1ns / 1ps

module pmm_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic [((12*WORD_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((3*WORD_BITS+2+7)/8)*8-1:0]   o_m_axis_tdata,
    input logic                                 o_m_axis_tlast,
    input logic                                 o_m_axis_tuser
);
    import pmm_pkg::*;

    logic [1:0] w_col;
    logic       w_acc;
    assign w_col = o_m_axis_tdata[1:0];
    assign w_acc = o_m_axis_tvalid & i_m_axis_tready;

    // Waiting input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && !o_s_axis_tready) |=>
        (i_s_axis_tvalid && $stable(i_s_axis_tdata)))
        else $error("input changed while waiting");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed under stall");

    // Last flag marks the translation column only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (w_col == COL_POS)))
        else $error("last flag off the translation column");

    // Columns of one pose follow each other in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid && w_col == $past(w_col) + 2'd1 &&
         o_m_axis_tuser == $past(o_m_axis_tuser)))
        else $error("column sequence broken");

    // Degenerate pose has zero basis columns
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser && w_col != COL_POS) |->
        (o_m_axis_tdata[3*WORD_BITS+1:2] == '0))
        else $error("degenerate pose with nonzero basis");

endmodule

bind pose_to_model_matrix_unit pmm_checker #(.WORD_BITS(WORD_BITS)) u_pmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
